// ===== hdl/speck64_128_block_encrypt_macros.svh =====
// assertion helpers for the speck block
`ifndef SPECK64_128_BLOCK_ENCRYPT_MACROS_SVH
`define SPECK64_128_BLOCK_ENCRYPT_MACROS_SVH

`ifndef ASSERT_OFF

// property checked on every rising edge outside reset
`define SPK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every rising edge, reset included
`define SPK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SPK_ASSERT(lbl, clk, rst, prop, msg)

`define SPK_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== hdl/spk_pkg.sv =====
package spk_pkg;

  localparam int WORD_W = 32;
  localparam int ROUNDS_MAX = 27;
  localparam int ROUND_COUNT_DEFAULT = 27;
  localparam int ROT_X = 8;
  localparam int ROT_Y = 3;
  localparam int CFG_INDEX_W = 2;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t KEY_RESET_0 = 32'h3322_1100;
  localparam word_t KEY_RESET_1 = 32'h7766_5544;
  localparam word_t KEY_RESET_2 = 32'hbbaa_9988;
  localparam word_t KEY_RESET_3 = 32'hffee_ddcc;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY_WORD_0 = 2'd0,
    REG_KEY_WORD_1 = 2'd1,
    REG_KEY_WORD_2 = 2'd2,
    REG_KEY_WORD_3 = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    word_t a;
    word_t b;
  } pair_t;

  // block state and key schedule state carried together down the pipe
  typedef struct packed {
    word_t x;
    word_t y;
    word_t rk;
    word_t l0;
    word_t l1;
    word_t l2;
  } stage_t;

  function automatic pair_t arx_round(word_t a, word_t b, word_t k);
    pair_t r;
    word_t na;
    na = (a >> ROT_X) | (a << (WORD_W - ROT_X));
    na = (na + b) ^ k;
    r.a = na;
    r.b = ((b << ROT_Y) | (b >> (WORD_W - ROT_Y))) ^ na;
    return r;
  endfunction

endpackage

// ===== hdl/speck64_128_block_encrypt.sv =====
// Speck64/128 encryption, one round per register stage. A block enters on
// every cycle the output side is not stalled; its ciphertext leaves the
// last stage of the round pipeline. Each stage holds one data round and one
// key schedule round side by side, so the key words are taken at entry and
// a key write applies to blocks accepted after it. A stall on the output
// freezes the whole pipe.
`include "speck64_128_block_encrypt_macros.svh"

module speck64_128_block_encrypt #(
  parameter int ROUND_COUNT = spk_pkg::ROUND_COUNT_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [spk_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [spk_pkg::WORD_W-1:0]      cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [63:0]                     s_axis_tdata,  // plain_low, plain_high
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [63:0]                     m_axis_tdata   // cipher_low, cipher_high
);

  localparam int W = spk_pkg::WORD_W;

  spk_pkg::word_t key0;
  spk_pkg::word_t key1;
  spk_pkg::word_t key2;
  spk_pkg::word_t key3;

  always_ff @(posedge clk) begin
    if (rst) begin
      key0 <= spk_pkg::KEY_RESET_0;
      key1 <= spk_pkg::KEY_RESET_1;
      key2 <= spk_pkg::KEY_RESET_2;
      key3 <= spk_pkg::KEY_RESET_3;
    end else if (cfg_we) begin
      case (spk_pkg::cfg_reg_t'(cfg_index))
        spk_pkg::REG_KEY_WORD_0: key0 <= cfg_data;
        spk_pkg::REG_KEY_WORD_1: key1 <= cfg_data;
        spk_pkg::REG_KEY_WORD_2: key2 <= cfg_data;
        spk_pkg::REG_KEY_WORD_3: key3 <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                    adv;
  logic [ROUND_COUNT:0]    vld;
  spk_pkg::stage_t         st [ROUND_COUNT+1];

  assign adv           = !vld[ROUND_COUNT] || m_axis_tready;
  assign s_axis_tready = adv;

  always_comb begin
    vld[0]   = s_axis_tvalid;
    st[0].x  = s_axis_tdata[W-1:0];
    st[0].y  = s_axis_tdata[2*W-1:W];
    st[0].rk = key0;
    st[0].l0 = key1;
    st[0].l1 = key2;
    st[0].l2 = key3;
  end

  for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_round
    spk_round #(
      .ROUND_INDEX(i)
    ) u_round (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_valid (vld[i]),
      .in_stage (st[i]),
      .out_valid(vld[i+1]),
      .out_stage(st[i+1])
    );
  end

  assign m_axis_tvalid = vld[ROUND_COUNT];
  assign m_axis_tdata  = {st[ROUND_COUNT].y, st[ROUND_COUNT].x};

  `SPK_ASSERT(a_stall_freezes, clk, rst, !adv |=> $stable(vld[ROUND_COUNT:1]), "pipe moved during stall")
  `SPK_ASSERT(a_entry_valid, clk, rst, s_axis_tvalid && s_axis_tready |=> vld[1], "accepted beat lost at entry")
  `SPK_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_axis_tvalid, "output valid after reset")

endmodule

// ===== hdl/spk_round.sv =====
module spk_round #(
  parameter int ROUND_INDEX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  spk_pkg::stage_t in_stage,
  output logic            out_valid,
  output spk_pkg::stage_t out_stage
);

  localparam spk_pkg::word_t RI = spk_pkg::WORD_W'(ROUND_INDEX);

  spk_pkg::pair_t  data_r;
  spk_pkg::pair_t  key_r;
  spk_pkg::stage_t stage_next;

  always_comb begin
    data_r = spk_pkg::arx_round(in_stage.x, in_stage.y, in_stage.rk);
    // schedule round on the oldest key word, round index as key
    key_r = spk_pkg::arx_round(in_stage.l0, in_stage.rk, RI);
    stage_next.x  = data_r.a;
    stage_next.y  = data_r.b;
    stage_next.rk = key_r.b;
    stage_next.l0 = in_stage.l1;
    stage_next.l1 = in_stage.l2;
    stage_next.l2 = key_r.a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_stage <= stage_next;
    end
  end

endmodule

// ===== tb/tb_speck64_128_block_encrypt.sv =====
module tb_speck64_128_block_encrypt;

  localparam int ROUNDS = spk_pkg::ROUND_COUNT_DEFAULT;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    spk_pkg::word_t cipher_low;
    spk_pkg::word_t cipher_high;
  } cipher_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [spk_pkg::CFG_INDEX_W-1:0] cfg_index = spk_pkg::REG_KEY_WORD_0;
  spk_pkg::word_t                  cfg_data = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [63:0]                     s_axis_tdata = '0;  // plain_low, plain_high
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [63:0]                     m_axis_tdata;       // cipher_low, cipher_high

  speck64_128_block_encrypt dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // key words as the block should hold them, indexed by register
  spk_pkg::word_t key_reg [4];
  logic [63:0]    plain_q [$];
  cipher_t        cipher_q [$];
  int             fail_count = 0;
  bit             burst = 1'b0;
  bit             hold_req = 1'b0;
  int             send_gap = 0;
  int             stall_left = 0;
  int             hold_left = 0;
  bit             rdy;
  cipher_t        want;

  function automatic int draw_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // full encryption, schedule rounds run alongside the data rounds
  function automatic cipher_t speck_encrypt(spk_pkg::word_t x, spk_pkg::word_t y);
    spk_pkg::word_t rk;
    spk_pkg::word_t sched [3];
    int             i;
    int             s;
    cipher_t        c;
    rk = key_reg[spk_pkg::REG_KEY_WORD_0];
    sched[0] = key_reg[spk_pkg::REG_KEY_WORD_1];
    sched[1] = key_reg[spk_pkg::REG_KEY_WORD_2];
    sched[2] = key_reg[spk_pkg::REG_KEY_WORD_3];
    for (i = 0; i < ROUNDS; i++) begin
      s = i % 3;
      x = ({x[7:0], x[31:8]} + y) ^ rk;
      y = {y[28:0], y[31:29]} ^ x;
      sched[s] = ({sched[s][7:0], sched[s][31:8]} + rk) ^ spk_pkg::word_t'(i);
      rk = {rk[28:0], rk[31:29]} ^ sched[s];
    end
    c.cipher_high = x;
    c.cipher_low = y;
    return c;
  endfunction

  task automatic send_block(spk_pkg::word_t hi, spk_pkg::word_t lo);
    plain_q.push_back({lo, hi});
  endtask

  task automatic send_random(int n);
    int             i;
    spk_pkg::word_t hi;
    spk_pkg::word_t lo;
    for (i = 0; i < n; i++) begin
      hi = $urandom;
      lo = $urandom;
      // now and then pin a word to an extreme
      case ($urandom_range(19))
        0: hi = '0;
        1: hi = '1;
        2: lo = '0;
        3: lo = '1;
        default: ;
      endcase
      send_block(hi, lo);
    end
  endtask

  task automatic write_reg(spk_pkg::cfg_reg_t idx, spk_pkg::word_t val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    key_reg[idx] = val;
  endtask

  task automatic load_key(spk_pkg::word_t k0, spk_pkg::word_t k1,
                          spk_pkg::word_t k2, spk_pkg::word_t k3);
    write_reg(spk_pkg::REG_KEY_WORD_0, k0);
    write_reg(spk_pkg::REG_KEY_WORD_1, k1);
    write_reg(spk_pkg::REG_KEY_WORD_2, k2);
    write_reg(spk_pkg::REG_KEY_WORD_3, k3);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for every beat to come back, then let the pipe settle
  task automatic drain();
    while (plain_q.size() != 0 || s_axis_tvalid || cipher_q.size() != 0)
      @(posedge clk);
    repeat (ROUNDS + 8) @(posedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        cipher_q.push_back(speck_encrypt(s_axis_tdata[31:0], s_axis_tdata[63:32]));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (plain_q.size() != 0) begin
          s_axis_tdata <= plain_q.pop_front();
          s_axis_tvalid <= 1'b1;
          send_gap = burst ? 0 : draw_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      rdy = 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      rdy = 1'b0;
    end else if (burst) begin
      rdy = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else begin
      rdy = 1'b1;
      stall_left = draw_gap();
    end
    m_axis_tready <= rdy;
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (cipher_q.size() == 0) begin
        $error("unexpected ciphertext beat %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = cipher_q.pop_front();
        if (m_axis_tdata[31:0] !== want.cipher_high) begin
          $error("cipher_high: expected %h, got %h", want.cipher_high, m_axis_tdata[31:0]);
          fail_count++;
        end
        if (m_axis_tdata[63:32] !== want.cipher_low) begin
          $error("cipher_low: expected %h, got %h", want.cipher_low, m_axis_tdata[63:32]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int i;
    key_reg[spk_pkg::REG_KEY_WORD_0] = spk_pkg::KEY_RESET_0;
    key_reg[spk_pkg::REG_KEY_WORD_1] = spk_pkg::KEY_RESET_1;
    key_reg[spk_pkg::REG_KEY_WORD_2] = spk_pkg::KEY_RESET_2;
    key_reg[spk_pkg::REG_KEY_WORD_3] = spk_pkg::KEY_RESET_3;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset key, corner plaintexts
    send_block('0, '0);
    send_block('1, '1);
    send_block('0, '1);
    send_block('1, '0);
    send_block(32'h8000_0000, 32'h0000_0001);
    send_block(32'h0000_0001, 32'h8000_0000);
    send_block(32'ha5a5_a5a5, 32'h5a5a_5a5a);
    for (i = 0; i < 8; i++)
      send_block(spk_pkg::word_t'(1) << (i * 4 + 3), ~(spk_pkg::word_t'(1) << (i * 4)));
    drain();

    // published test key and plaintext
    load_key(32'h0302_0100, 32'h0b0a_0908, 32'h1312_1110, 32'h1b1a_1918);
    send_block(32'h3b72_6574, 32'h7475_432d);
    send_block('0, '0);
    send_block('1, '1);
    drain();

    load_key('0, '0, '0, '0);
    send_block('0, '0);
    send_random(150);
    drain();

    load_key('1, '1, '1, '1);
    send_block('1, '1);
    send_random(150);
    drain();

    // back-to-back with no idling on either side
    load_key($urandom, $urandom, $urandom, $urandom);
    burst = 1'b1;
    send_random(280);
    drain();
    burst = 1'b0;

    load_key($urandom, $urandom, $urandom, $urandom);
    send_random(280);
    drain();

    // long receiver hold-off while the sender keeps offering
    load_key($urandom, $urandom, $urandom, $urandom);
    burst = 1'b1;
    send_random(280);
    hold_req = 1'b1;
    drain();
    burst = 1'b0;

    // single word change: the schedule must follow it
    write_reg(spk_pkg::REG_KEY_WORD_2, $urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    send_random(280);
    drain();

    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #1500000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
